FILE: hdl/weighted_moving_average_macros.svh
// Assertion helpers for the weighted moving average
`ifndef WEIGHTED_MOVING_AVERAGE_MACROS_SVH
`define WEIGHTED_MOVING_AVERAGE_MACROS_SVH

// same-cycle implication
`define WMA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/wma_pkg.sv
package wma_pkg;

  localparam int Taps       = 8;
  localparam int NumWeights = 8;

  localparam int SampleW = 16;
  localparam int WeightW = 8;
  localparam int TapIdxW = 3;
  // sum of Taps products of 16x9 signed
  localparam int AccW    = 27;
  localparam int MagW    = 26;
  localparam int WsumW   = 11;
  localparam int QuoW    = 16;
  localparam int CntW    = 4;

  localparam int PAddrW  = 5;
  localparam int PDataW  = 32;

  localparam logic CmdPush = 1'b0;
  localparam logic CmdFill = 1'b1;

  function automatic logic [WeightW-1:0] weight_rst(input int idx);
    logic [WeightW-1:0] w;
    w = '0;
    case (idx)
      0:       w = 8'd8;
      1:       w = 8'd2;
      2:       w = 8'd1;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

FILE: hdl/wma_if.sv
interface wma_in_if;
  import wma_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic signed [SampleW-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink (input valid, input cmd, input value, output ready);
endinterface

interface wma_out_if;
  import wma_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] average;
  logic                      no_weights;

  modport source (output valid, output average, output no_weights, input ready);
  modport sink (input valid, input average, input no_weights, output ready);
endinterface

FILE: hdl/weighted_moving_average.sv
// Weighted moving average over up to eight 16-bit samples.
// sample_i: valid/ready channel carrying cmd (0 push, 1 fill) and a signed value.
// result_o: valid/ready channel carrying average and the no_weights flag;
//   exactly one result per transfer on sample_i.
// Weights sit behind an APB-style port, one 8-bit register per tap at 4*i;
//   the active taps are the leading run of nonzero weights.
// One shared multiply-accumulate steps through the active taps, one a cycle,
//   then a restoring divider produces one quotient bit a cycle (16 steps).
// After a transfer the sequencer runs MAC, PREP, DIV and DONE, then returns to idle;
//   with no active tap PREP goes straight to DONE and the divider is skipped.
// sample_i is ready only while the sequencer is idle, so no new transfer is taken
//   before the previous item has left the sequencer.
// The result is held in an output register. If the receiver stalls, the next
//   item may still be taken and worked on, but its result waits in the last
//   sequencer step until the output register is free.
// Reset clears the history to zero, loads the weights 8, 2, 1, 0, 0, 0, 0, 0
//   and leaves the output empty.
module weighted_moving_average (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  wma_in_if.sink                       sample_i,
  wma_out_if.source                    result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wma_pkg::PAddrW-1:0]   paddr,
  input  logic [wma_pkg::PDataW-1:0]   pwdata,
  output logic [wma_pkg::PDataW-1:0]   prdata,
  output logic                         pready
);
  import wma_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_PREP,
    S_DIV,
    S_DONE
  } state_e;

  state_e                           state_q;
  logic [WeightW-1:0]               weight_q [NumWeights];
  logic signed [SampleW-1:0]        hist_q [Taps];
  logic [Taps*WeightW-1:0]          wrk_q;
  logic [TapIdxW-1:0]               k_q;
  logic signed [AccW-1:0]           acc_q;
  logic [WsumW-1:0]                 wsum_q;
  logic [WsumW-1:0]                 rem_q;
  logic [QuoW-1:0]                  quo_q;
  logic [CntW-1:0]                  cnt_q;
  logic                             neg_q;
  logic                             nw_q;
  logic                             out_valid_q;
  logic signed [SampleW-1:0]        out_avg_q;
  logic                             out_nw_q;

  logic                             in_xfer;
  logic                             cfg_wr;
  logic [TapIdxW-1:0]               cfg_idx;
  logic [Taps*WeightW-1:0]          weights_flat;
  logic [WeightW-1:0]               cur_w;
  logic signed [WeightW+SampleW:0]  prod;
  logic [AccW-1:0]                  mag;
  logic [WsumW:0]                   shifted;
  logic [WsumW:0]                   trial;
  logic                             ge;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[PAddrW-1:2];
  assign prdata  = {{(PDataW-WeightW){1'b0}}, weight_q[cfg_idx]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumWeights; i++) begin
        weight_q[i] <= weight_rst(i);
      end
    end else if (cfg_wr) begin
      weight_q[cfg_idx] <= pwdata[WeightW-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < Taps; i++) begin
      weights_flat[i*WeightW +: WeightW] = weight_q[i];
    end
  end

  assign sample_i.ready      = (state_q == S_IDLE);
  assign in_xfer             = sample_i.valid && sample_i.ready;
  assign result_o.valid      = out_valid_q;
  assign result_o.average    = out_avg_q;
  assign result_o.no_weights = out_nw_q;

  assign cur_w   = wrk_q[WeightW-1:0];
  assign prod    = hist_q[k_q] * $signed({1'b0, cur_w});
  assign mag     = acc_q[AccW-1] ? (-acc_q) : acc_q;
  assign shifted = {rem_q, quo_q[QuoW-1]};
  assign trial   = shifted - {1'b0, wsum_q};
  assign ge      = (shifted >= {1'b0, wsum_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Taps; i++) begin
        hist_q[i] <= '0;
      end
    end else if (in_xfer) begin
      if (sample_i.cmd == CmdFill) begin
        for (int i = 0; i < Taps; i++) begin
          hist_q[i] <= sample_i.value;
        end
      end else begin
        for (int i = Taps - 1; i > 0; i--) begin
          hist_q[i] <= hist_q[i-1];
        end
        hist_q[0] <= sample_i.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wrk_q       <= '0;
      k_q         <= '0;
      acc_q       <= '0;
      wsum_q      <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      nw_q        <= 1'b0;
      out_valid_q <= 1'b0;
      out_avg_q   <= '0;
      out_nw_q    <= 1'b0;
    end else begin
      if (state_q == S_DONE && (!out_valid_q || result_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            wrk_q   <= weights_flat;
            k_q     <= '0;
            acc_q   <= '0;
            wsum_q  <= '0;
            state_q <= S_MAC;
          end
        end
        S_MAC: begin
          if (cur_w == '0) begin
            state_q <= S_PREP;
          end else begin
            acc_q  <= acc_q + AccW'(prod);
            wsum_q <= wsum_q + WsumW'(cur_w);
            wrk_q  <= wrk_q >> WeightW;
            if (k_q == TapIdxW'(Taps - 1)) begin
              state_q <= S_PREP;
            end else begin
              k_q <= k_q + 1'b1;
            end
          end
        end
        S_PREP: begin
          cnt_q <= '0;
          if (wsum_q == '0) begin
            nw_q    <= 1'b1;
            neg_q   <= 1'b0;
            quo_q   <= '0;
            state_q <= S_DONE;
          end else begin
            // quotient fits 16 bits, so the upper bits start below the divisor
            nw_q    <= 1'b0;
            neg_q   <= acc_q[AccW-1];
            rem_q   <= WsumW'(mag[MagW-1:QuoW]);
            quo_q   <= mag[QuoW-1:0];
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q <= ge ? trial[WsumW-1:0] : shifted[WsumW-1:0];
          quo_q <= {quo_q[QuoW-2:0], ge};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(QuoW - 1)) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || result_o.ready) begin
            out_avg_q   <= neg_q ? $signed(-quo_q) : $signed(quo_q);
            out_nw_q    <= nw_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`include "weighted_moving_average_macros.svh"

  `WMA_ASSERT_NEXT(a_xfer_starts_mac, in_xfer, state_q == S_MAC, "transfer did not start MAC")
  `WMA_ASSERT_SAME(a_div_rem_bound, state_q == S_DIV, (wsum_q != '0) && (rem_q < wsum_q), "divider remainder out of range")
  `WMA_ASSERT_SAME(a_nw_zero_avg, out_valid_q && out_nw_q, out_avg_q == '0, "no_weights with nonzero average")

endmodule

FILE: tb/weighted_moving_average_tb.sv
`timescale 1ns / 100ps

module weighted_moving_average_tb;
  import wma_pkg::*;

  localparam int CycleLimit = 500000;
  localparam int DrainCycles = 40;

  typedef struct packed {
    logic signed [SampleW-1:0] average;
    logic                      no_weights;
  } wma_result_t;

  localparam logic [WeightW-1:0] WeightReset [NumWeights] =
    '{8'd8, 8'd2, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};

  logic clk_i;
  logic rst_ni;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PAddrW-1:0]  paddr;
  logic [PDataW-1:0]  pwdata;
  logic [PDataW-1:0]  prdata;
  logic               pready;

  wma_in_if  sample_if ();
  wma_out_if result_if ();

  weighted_moving_average u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .result_o (result_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  logic [WeightW-1:0]        weight_q [NumWeights];
  logic signed [SampleW-1:0] history_q [Taps];
  wma_result_t               expected_averages [$];

  int  mismatches;
  int  cycle_cnt;
  bit  gap_en;
  bit  stall_en;
  int  hold_cnt;
  int  stall_left;

  always #5 clk_i = ~clk_i;

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // shift or fill the history, then weighted mean over the leading nonzero weights
  function automatic wma_result_t filter_step(input logic cmd,
                                              input logic signed [SampleW-1:0] value);
    wma_result_t res;
    longint      acc;
    longint      wsum;
    bit          active;
    acc    = 0;
    wsum   = 0;
    active = 1'b1;
    if (cmd == CmdFill) begin
      for (int k = 0; k < Taps; k++) history_q[k] = value;
    end else begin
      for (int k = Taps - 1; k > 0; k--) history_q[k] = history_q[k-1];
      history_q[0] = value;
    end
    for (int k = 0; k < Taps && k < NumWeights; k++) begin
      if (weight_q[k] == '0) active = 1'b0;
      if (active) begin
        acc  += longint'(history_q[k]) * longint'(weight_q[k]);
        wsum += longint'(weight_q[k]);
      end
    end
    if (wsum == 0) begin
      res.average    = '0;
      res.no_weights = 1'b1;
    end else begin
      res.average    = SampleW'(acc / wsum);
      res.no_weights = 1'b0;
    end
    return res;
  endfunction

  task automatic apb_access(input logic wr, input int idx, input logic [PDataW-1:0] wdata,
                            output logic [PDataW-1:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = PAddrW'(4 * idx);
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_weight_reg(input int idx, input logic [WeightW-1:0] want);
    logic [PDataW-1:0] rdata;
    apb_access(1'b0, idx, $urandom, rdata);
    if (rdata[WeightW-1:0] !== want)
      report($sformatf("weight_%0d reads %0d, want %0d", idx, rdata[WeightW-1:0], want));
  endtask

  // upper data bits are random; only the low byte is kept
  task automatic write_weight(input int idx, input logic [WeightW-1:0] w);
    logic [PDataW-1:0] rdata;
    apb_access(1'b1, idx, {24'($urandom), w}, rdata);
    weight_q[idx] = w;
    check_weight_reg(idx, w);
  endtask

  task automatic write_all_weights(input logic [WeightW-1:0] w [NumWeights]);
    for (int i = 0; i < NumWeights; i++) write_weight(i, w[i]);
  endtask

  task automatic send_sample(input logic cmd, input logic signed [SampleW-1:0] value);
    @(negedge clk_i);
    if (gap_en && $urandom_range(0, 3) == 0) begin
      sample_if.valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    sample_if.valid = 1'b1;
    sample_if.cmd   = cmd;
    sample_if.value = value;
    do @(posedge clk_i); while (!sample_if.ready);
    expected_averages.push_back(filter_step(cmd, value));
  endtask

  task automatic drain();
    @(negedge clk_i);
    sample_if.valid = 1'b0;
    while (expected_averages.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic signed [SampleW-1:0] rand_sample();
    logic signed [SampleW-1:0] v;
    case ($urandom_range(0, 11))
      0:       v = 16'sh7fff;
      1:       v = 16'sh8000;
      2:       v = '0;
      3:       v = -16'sd1;
      default: v = SampleW'($urandom);
    endcase
    return v;
  endfunction

  task automatic load_random_weights();
    int                 active_n;
    logic [WeightW-1:0] w;
    active_n = $urandom_range(0, NumWeights);
    for (int i = 0; i < NumWeights; i++) begin
      if (i < active_n) w = ($urandom_range(0, 5) == 0) ? 8'd255 : 8'($urandom_range(1, 255));
      else if (i == active_n) w = '0;
      else w = 8'($urandom_range(0, 255));
      write_weight(i, w);
    end
  endtask

  task automatic send_random_items(input int n);
    repeat (n) send_sample(($urandom_range(0, 9) == 0) ? CmdFill : CmdPush, rand_sample());
  endtask

  task automatic test_reset_defaults();
    for (int i = 0; i < NumWeights; i++) check_weight_reg(i, WeightReset[i]);
    send_sample(CmdPush, 16'sh7fff);
    send_sample(CmdPush, 16'sh8000);
    send_sample(CmdPush, -16'sd1);
    send_sample(CmdFill, 16'sd0);
    send_sample(CmdPush, 16'sd1);
    drain();
  endtask

  task automatic test_extreme_weights();
    write_all_weights('{default: 8'd255});
    send_sample(CmdFill, 16'sh8000);
    send_sample(CmdPush, 16'sh7fff);
    send_sample(CmdFill, 16'sh7fff);
    send_sample(CmdPush, 16'sh8000);
    send_sample(CmdPush, -16'sd7);
    drain();
    write_all_weights('{default: 8'd1});
    send_sample(CmdFill, 16'sd0);
    send_sample(CmdPush, -16'sd3);
    send_sample(CmdPush, 16'sd2);
    drain();
  endtask

  task automatic test_zero_weights();
    // a zero in the middle ends the active taps
    write_all_weights('{8'd3, 8'd7, 8'd0, 8'd200, 8'd255, 8'd1, 8'd9, 8'd4});
    send_sample(CmdFill, 16'sh1234);
    send_sample(CmdPush, -16'sd100);
    send_sample(CmdPush, 16'sd5);
    drain();
    // no active tap: history still moves
    write_weight(0, 8'd0);
    send_sample(CmdPush, 16'sh7fff);
    send_sample(CmdFill, 16'sh8000);
    send_sample(CmdPush, 16'sd9);
    drain();
    write_weight(0, 8'd1);
    send_sample(CmdPush, 16'sd11);
    send_sample(CmdPush, 16'sh8000);
    drain();
  endtask

  task automatic test_output_backpressure();
    write_all_weights('{8'd5, 8'd4, 8'd3, 8'd2, 8'd1, 8'd6, 8'd7, 8'd8});
    @(negedge clk_i);
    hold_cnt = 400;
    send_random_items(10);
    drain();
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 7; phase++) begin
      load_random_weights();
      send_random_items(100);
      drain();
    end
  endtask

  task automatic test_tail_no_idle();
    gap_en   = 1'b0;
    stall_en = 1'b0;
    load_random_weights();
    send_random_items(100);
    drain();
  endtask

  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      result_if.ready = 1'b0;
      hold_cnt--;
    end else if (stall_left > 0) begin
      result_if.ready = 1'b0;
      stall_left--;
    end else if (stall_en && $urandom_range(0, 7) == 0) begin
      result_if.ready = 1'b0;
      stall_left = $urandom_range(0, 12);
    end else begin
      result_if.ready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    wma_result_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (expected_averages.size() == 0) begin
        report("result transfer with nothing pending");
      end else begin
        want = expected_averages.pop_front();
        if (result_if.average !== want.average)
          report($sformatf("average %0d, want %0d", result_if.average, want.average));
        if (result_if.no_weights !== want.no_weights)
          report($sformatf("no_weights %b, want %b", result_if.no_weights, want.no_weights));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("weighted_moving_average test failed");
      $finish;
    end
  end

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    sample_if.valid  = 1'b0;
    sample_if.cmd    = CmdPush;
    sample_if.value  = '0;
    result_if.ready  = 1'b0;
    mismatches       = 0;
    cycle_cnt        = 0;
    hold_cnt         = 0;
    stall_left       = 0;
    gap_en           = 1'b1;
    stall_en         = 1'b1;
    for (int i = 0; i < NumWeights; i++) weight_q[i] = WeightReset[i];
    for (int k = 0; k < Taps; k++) history_q[k] = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_extreme_weights();
    test_zero_weights();
    test_output_backpressure();
    test_random_phases();
    test_tail_no_idle();

    if (mismatches == 0) begin
      $display("weighted_moving_average test passed");
    end else begin
      $display("weighted_moving_average test failed");
    end
    $finish;
  end

endmodule
